// File: design/conv3x3_blur_sharpen_defines.svh
`ifndef CONV3X3_BLUR_SHARPEN_DEFINES_SVH
`define CONV3X3_BLUR_SHARPEN_DEFINES_SVH

// same-cycle check
`define CNV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check
`define CNV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cnv_pkg.sv
`timescale 1ns / 1ps

package cnv_pkg;

    localparam int PIX_W       = 8;
    localparam int NUM_CH      = 3;
    localparam int TAPS        = 9;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 16;
    localparam int WIDTH_W     = 11;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int SUM_W       = 12;
    localparam int DIV9_MUL_W  = 13;
    localparam int DIV9_SHIFT  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE   = 8'd3;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd1;

    localparam logic MODE_BLUR    = 1'b0;
    localparam logic MODE_SHARPEN = 1'b1;
    localparam logic COLOR_GRAY   = 1'b0;
    localparam logic COLOR_RGB    = 1'b1;

    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
    localparam logic [PIX_W-1:0]      PIX_MAX  = 8'd255;

    typedef logic [PIX_W-1:0]        chan_t;
    typedef logic [NUM_CH*PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] int_col;
        logic [ROW_W-1:0] int_row;
        logic             has_int;
        logic             has_bord;
    } tag_t;

endpackage

// File: design/cnv_if.sv
`timescale 1ns / 1ps

interface cnv_cfg_if import cnv_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface cnv_pixel_if import cnv_pkg::*;;
    logic  valid;
    logic  ready;
    chan_t sample_0;
    chan_t sample_1;
    chan_t sample_2;

    modport source (output valid, sample_0, sample_1, sample_2, input ready);
    modport sink   (input valid, sample_0, sample_1, sample_2, output ready);
endinterface

interface cnv_result_if import cnv_pkg::*;;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] out_row;
    chan_t            result_0;
    chan_t            result_1;
    chan_t            result_2;
    logic             last_of_input;

    modport source (output valid, out_column, out_row, result_0, result_1, result_2,
                    last_of_input, input ready);
    modport sink   (input valid, out_column, out_row, result_0, result_1, result_2,
                    last_of_input, output ready);
endinterface

// File: design/cnv_lane.sv
`timescale 1ns / 1ps

module cnv_lane import cnv_pkg::*;
(
    input  logic  clk,
    input  logic  load,
    input  logic  filter_mode,
    input  chan_t taps [TAPS],
    output chan_t res
);

    localparam int PROD_W = SUM_W + DIV9_MUL_W;

    logic [SUM_W-1:0]        sum_next;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        pos;
    logic [SUM_W-1:0]        neg;
    logic signed [SUM_W-1:0] sharp_next;
    logic signed [SUM_W-1:0] sharp_reg;
    logic [PROD_W-1:0]       prod;
    chan_t                   clamped;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            sum_next = sum_next + SUM_W'(taps[i]);
        end
        pos = SUM_W'({taps[4], 2'b00}) + SUM_W'(taps[4]);
        neg = SUM_W'(taps[1]) + SUM_W'(taps[3]) + SUM_W'(taps[5]) + SUM_W'(taps[7]);
        sharp_next = $signed(pos - neg);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg   <= sum_next;
            sharp_reg <= sharp_next;
        end
    end

    assign prod = PROD_W'(sum_reg) * PROD_W'(DIV9_MUL);

    always_comb
    begin
        if (sharp_reg[SUM_W-1])
        begin
            clamped = '0;
        end
        else if (sharp_reg[SUM_W-2:PIX_W] != '0)
        begin
            clamped = PIX_MAX;
        end
        else
        begin
            clamped = sharp_reg[PIX_W-1:0];
        end
    end

    assign res = (filter_mode == MODE_SHARPEN) ? clamped : prod[DIV9_SHIFT +: PIX_W];

endmodule

// File: design/cnv_front.sv
`timescale 1ns / 1ps

module cnv_front import cnv_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int CW = $clog2(MAX_WIDTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic [CW-1:0] addr,
    input  pix_t          px,
    input  tag_t          tag,
    input  logic          clr_en,
    input  logic [CW-1:0] clr_addr,
    input  logic          adv2,
    output logic          ready1,
    output logic          v2,
    output tag_t          tag2,
    output pix_t          px2,
    output pix_t          win [TAPS]
);

    localparam int ENT_W = 2 * $bits(pix_t);

    logic [ENT_W-1:0] mem [MAX_WIDTH];
    logic [ENT_W-1:0] rd_reg;
    logic [ENT_W-1:0] fwd_val_reg;
    logic             fwd_reg;
    logic             fwd_next;

    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;
    logic [CW-1:0] addr1_reg;
    pix_t          px1_reg;
    tag_t          tag1_reg;
    tag_t          tag2_reg;
    pix_t          px2_reg;
    pix_t          win_reg [TAPS];

    pix_t             up1;
    pix_t             mid1;
    logic             adv1;
    logic             we;
    logic [CW-1:0]    waddr;
    logic [ENT_W-1:0] wdata;

    assign {up1, mid1} = fwd_reg ? fwd_val_reg : rd_reg;

    assign adv1   = v1_reg && (!v2_reg || adv2);
    assign ready1 = !v1_reg || adv1;

    assign we    = clr_en || v1_reg;
    assign waddr = clr_en ? clr_addr : addr1_reg;
    assign wdata = clr_en ? '0 : {mid1, px1_reg};

    assign fwd_next = v1_reg && (addr1_reg == addr);
    assign v1_next  = load ? 1'b1 : (adv1 ? 1'b0 : v1_reg);
    assign v2_next  = adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_reg);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (load)
        begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr1_reg   <= addr;
            px1_reg     <= px;
            tag1_reg    <= tag;
            fwd_val_reg <= {mid1, px1_reg};
        end
        if (adv1)
        begin
            tag2_reg <= tag1_reg;
            px2_reg  <= px1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            fwd_reg <= 1'b0;
            for (int i = 0; i < TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            if (load)
            begin
                fwd_reg <= fwd_next;
            end
            if (adv1)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= up1;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= mid1;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= px1_reg;
            end
        end
    end

    assign v2   = v2_reg;
    assign tag2 = tag2_reg;
    assign px2  = px2_reg;
    assign win  = win_reg;

endmodule

// File: design/cnv_merge.sv
`timescale 1ns / 1ps

module cnv_merge import cnv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  tag_t  tag,
    input  pix_t  px,
    input  chan_t lane_res [NUM_CH],
    input  logic  color_mode,
    output logic  ready3,
    cnv_result_if.source result
);

    logic v3_reg, v3_next;
    tag_t tag3_reg;
    pix_t px3_reg;

    logic ov_int_reg, ov_int_next;
    logic ov_bord_reg, ov_bord_next;
    tag_t otag_reg;
    pix_t oint_reg;
    pix_t opx_reg;

    pix_t int_px;
    logic last_pend;
    logic out_fire;
    logic out_free;
    logic adv3;
    pix_t sel_px;

    assign int_px = {(color_mode == COLOR_RGB) ? lane_res[2] : chan_t'(0),
                     (color_mode == COLOR_RGB) ? lane_res[1] : chan_t'(0),
                     lane_res[0]};

    assign last_pend = ov_int_reg ^ ov_bord_reg;
    assign out_fire  = result.valid && result.ready;
    assign out_free  = !(ov_int_reg || ov_bord_reg) || (out_fire && last_pend);
    assign adv3      = v3_reg && out_free;
    assign ready3    = !v3_reg || adv3;

    assign v3_next = load ? 1'b1 : (adv3 ? 1'b0 : v3_reg);

    always_comb
    begin
        ov_int_next  = ov_int_reg;
        ov_bord_next = ov_bord_reg;
        if (adv3)
        begin
            ov_int_next  = tag3_reg.has_int;
            ov_bord_next = tag3_reg.has_bord;
        end
        else if (out_fire)
        begin
            if (ov_int_reg && ov_bord_reg)
            begin
                ov_int_next = 1'b0;
            end
            else
            begin
                ov_int_next  = 1'b0;
                ov_bord_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tag3_reg <= tag;
            px3_reg  <= px;
        end
        if (adv3)
        begin
            otag_reg <= tag3_reg;
            oint_reg <= int_px;
            opx_reg  <= px3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg      <= 1'b0;
            ov_int_reg  <= 1'b0;
            ov_bord_reg <= 1'b0;
        end
        else
        begin
            v3_reg      <= v3_next;
            ov_int_reg  <= ov_int_next;
            ov_bord_reg <= ov_bord_next;
        end
    end

    // interior result goes out ahead of the border pass-through
    assign sel_px               = ov_int_reg ? oint_reg : opx_reg;
    assign result.valid         = ov_int_reg || ov_bord_reg;
    assign result.out_column    = ov_int_reg ? otag_reg.int_col : otag_reg.col;
    assign result.out_row       = ov_int_reg ? otag_reg.int_row : otag_reg.row;
    assign result.result_0      = sel_px[0*PIX_W +: PIX_W];
    assign result.result_1      = sel_px[1*PIX_W +: PIX_W];
    assign result.result_2      = sel_px[2*PIX_W +: PIX_W];
    assign result.last_of_input = !(ov_int_reg && ov_bord_reg);

endmodule

// File: design/conv3x3_blur_sharpen.sv
`timescale 1ns / 1ps
// 3x3 box blur / sharpen filter on a raster-order pixel stream.
// cfg: register writes (index 0 width, 1 height, 2 filter mode, 3 color mode);
//   always ready; write only while the block is drained.
// pixel: one pixel per beat, gray in sample_0 or three color channels.
// result: up to two beats per pixel; an interior result for the pixel up and
//   left of the incoming one, then the incoming pixel itself when it lies on
//   the border. last_of_input marks the final beat caused by a pixel.
// Throughput: one pixel per cycle when result.ready is high and no clear
//   runs; a two-result pixel holds the single output register for both beats.
// Path: an accepted beat is registered in turn by the line store read, the
//   window, the lane adders and the lane multiply into the output register.
// Reset: counters, window and pipeline valids clear; then a clearing pass
//   zeroes every line store entry while pixel.ready stays low.
// Stall: when result.ready is low the output register holds, and back
//   pressure reaches pixel.ready once the three inner stages are full.

`include "conv3x3_blur_sharpen_defines.svh"

module conv3x3_blur_sharpen import cnv_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input logic          clk,
    input logic          rst_n,
    cnv_cfg_if.sink      cfg,
    cnv_pixel_if.sink    pixel,
    cnv_result_if.source result
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
    localparam logic [CW-1:0] CLR_LAST = CW'(MAX_WIDTH - 1);

    logic [WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;
    logic               filter_mode_reg;
    logic               color_mode_reg;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             clr_busy_reg;
    logic [CW-1:0]    clr_cnt_reg;

    logic [XW-1:0]    w_x;
    logic [ROW_W-1:0] h_eff;
    logic             out_range;
    logic [CW-1:0]    c;
    logic [ROW_W-1:0] r;
    logic             last_col;
    logic             last_row;
    logic             in_fire;
    pix_t             px;
    tag_t             tag;

    logic  ready1;
    logic  v2;
    logic  ready3;
    logic  adv2;
    tag_t  tag2;
    pix_t  px2;
    pix_t  win [TAPS];
    chan_t lane_taps [NUM_CH][TAPS];
    chan_t lane_res [NUM_CH];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= WIDTH_RESET;
            height_reg      <= HEIGHT_RESET;
            filter_mode_reg <= MODE_BLUR;
            color_mode_reg  <= COLOR_GRAY;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:  width_reg       <= cfg.data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg      <= cfg.data[ROW_W-1:0];
                REG_FILTER_MODE:  filter_mode_reg <= cfg.data[0];
                REG_COLOR_MODE:   color_mode_reg  <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_x = XW'(1);
        end
        else if (XW'(width_reg) > XW'(MAX_WIDTH))
        begin
            w_x = XW'(MAX_WIDTH);
        end
        else
        begin
            w_x = XW'(width_reg);
        end
        h_eff     = (height_reg == '0) ? ROW_W'(1) : height_reg;
        out_range = (XW'(col_reg) >= w_x) || (row_reg >= h_eff);
        c         = out_range ? '0 : col_reg;
        r         = out_range ? '0 : row_reg;
        last_col  = (XW'(c) == w_x - XW'(1));
        last_row  = (r == h_eff - ROW_W'(1));

        tag.col      = COL_W'(c);
        tag.row      = r;
        tag.int_col  = COL_W'(c - CW'(1));
        tag.int_row  = r - ROW_W'(1);
        tag.has_int  = (c >= CW'(2)) && (r >= ROW_W'(2));
        tag.has_bord = (r == '0) || last_row || (c == '0) || last_col;

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : r + ROW_W'(1);
        end
        else
        begin
            col_next = c + CW'(1);
            row_next = r;
        end
    end

    assign px = {(color_mode_reg == COLOR_RGB) ? pixel.sample_2 : chan_t'(0),
                 (color_mode_reg == COLOR_RGB) ? pixel.sample_1 : chan_t'(0),
                 pixel.sample_0};

    assign pixel.ready = !clr_busy_reg && ready1;
    assign in_fire     = pixel.valid && pixel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    cnv_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_fire),
        .addr     (c),
        .px       (px),
        .tag      (tag),
        .clr_en   (clr_busy_reg),
        .clr_addr (clr_cnt_reg),
        .adv2     (adv2),
        .ready1   (ready1),
        .v2       (v2),
        .tag2     (tag2),
        .px2      (px2),
        .win      (win)
    );

    assign adv2 = v2 && ready3;

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                lane_taps[k][i] = win[i][k*PIX_W +: PIX_W];
            end
        end
    end

    for (genvar k = 0; k < NUM_CH; k++)
    begin : g_lane
        cnv_lane u_lane (
            .clk         (clk),
            .load        (adv2),
            .filter_mode (filter_mode_reg),
            .taps        (lane_taps[k]),
            .res         (lane_res[k])
        );
    end

    cnv_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (adv2),
        .tag        (tag2),
        .px         (px2),
        .lane_res   (lane_res),
        .color_mode (color_mode_reg),
        .ready3     (ready3),
        .result     (result)
    );

    `CNV_ASSERT_NEXT(a_pair_follows, result.valid && result.ready && !result.last_of_input, result.valid, "second beat of a pixel missing")
    `CNV_ASSERT_NEXT(a_pair_column, result.valid && result.ready && !result.last_of_input, result.out_column == COL_W'($past(result.out_column) + 1'b1), "border beat not one column right of interior beat")
    `CNV_ASSERT_NEXT(a_col_in_range, in_fire, XW'(col_reg) < $past(w_x), "column counter beyond image width")
    `CNV_ASSERT_NOW(a_no_pixel_in_clear, clr_busy_reg, !in_fire, "pixel taken during line store clear")

endmodule
